// ===== hw/rtl/gbfr_pkg.sv =====
package gbfr_pkg;

    localparam int unsigned MaxPayloadWidth = 16;
    localparam int unsigned CfgIndexWidth   = 3;
    localparam int unsigned CfgDataWidth    = 16;

    localparam logic [15:0] MaxPayloadReset = 16'd1024;
    localparam logic [7:0]  IdleLimitReset  = 8'd50;
    localparam logic [7:0]  SyncFirstReset  = 8'hB5;
    localparam logic [7:0]  SyncSecondReset = 8'h62;
    localparam logic [7:0]  IdleByte        = 8'hFF;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_MAX_PAYLOAD = 3'd0,
        REG_IDLE_LIMIT  = 3'd1,
        REG_SYNC_FIRST  = 3'd2,
        REG_SYNC_SECOND = 3'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_CKA_BAD  = 3'd3,
        EV_CKB_BAD  = 3'd4,
        EV_OVERFLOW = 3'd5
    } event_t;

    typedef enum logic [8:0] {
        ST_SYNC1   = 9'b000000001,
        ST_SYNC2   = 9'b000000010,
        ST_CLASS   = 9'b000000100,
        ST_ID      = 9'b000001000,
        ST_LEN1    = 9'b000010000,
        ST_LEN2    = 9'b000100000,
        ST_PAYLOAD = 9'b001000000,
        ST_CK1     = 9'b010000000,
        ST_CK2     = 9'b100000000
    } parse_state_t;

    typedef struct packed {
        logic [MaxPayloadWidth-1:0] max_payload;
        logic [7:0]                 idle_limit;
        logic [7:0]                 sync_first;
        logic [7:0]                 sync_second;
    } cfg_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] frame_length;
        logic [7:0]  idle_count;
        logic        idle_timeout;
    } result_t;

    typedef struct packed {
        logic hunting;
    } core_status_t;

endpackage

// ===== hw/rtl/gbfr_parser_core.sv =====
module gbfr_parser_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  gbfr_pkg::cfg_t    cfg,
    output gbfr_pkg::result_t result,
    output gbfr_pkg::core_status_t status
);
    import gbfr_pkg::*;

    parse_state_t state_reg, state_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  ff_reg, ff_next;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] pos_inc;
    logic        restart;
    event_t      ev;
    logic [7:0]  pbyte;
    logic [15:0] pidx;

    assign acc_a   = sum_a_reg + rx_byte;
    assign acc_b   = sum_b_reg + acc_a;
    assign pos_inc = pos_reg + 16'd1;

    always_comb begin
        state_next  = state_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        ff_next     = ff_reg;
        restart     = 1'b0;
        ev          = EV_NONE;
        pbyte       = 8'd0;
        pidx        = 16'd0;
        unique case (state_reg)
            ST_SYNC1: begin
                if (rx_byte == cfg.sync_first) begin
                    state_next = ST_SYNC2;
                    ff_next    = 8'd0;
                end else if (rx_byte == IdleByte && ff_reg != 8'hFF) begin
                    ff_next = ff_reg + 8'd1;
                end
            end
            ST_SYNC2: begin
                if (rx_byte == cfg.sync_second) begin
                    state_next = ST_CLASS;
                end else begin
                    restart = 1'b1;
                end
            end
            ST_CLASS: begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                class_next = rx_byte;
                state_next = ST_ID;
            end
            ST_ID: begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                id_next    = rx_byte;
                state_next = ST_LEN1;
            end
            ST_LEN1: begin
                sum_a_next  = acc_a;
                sum_b_next  = acc_b;
                length_next = {8'd0, rx_byte};
                state_next  = ST_LEN2;
            end
            ST_LEN2: begin
                sum_a_next  = acc_a;
                sum_b_next  = acc_b;
                length_next = {rx_byte, length_reg[7:0]};
                state_next  = ({rx_byte, length_reg[7:0]} != 16'd0) ? ST_PAYLOAD : ST_CK1;
            end
            ST_PAYLOAD: begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                if (pos_reg >= 16'(cfg.max_payload)) begin
                    ev      = EV_OVERFLOW;
                    restart = 1'b1;
                end else begin
                    ev       = EV_PAYLOAD;
                    pbyte    = rx_byte;
                    pidx     = pos_reg;
                    pos_next = pos_inc;
                    if (pos_inc >= length_reg) begin
                        state_next = ST_CK1;
                    end
                end
            end
            ST_CK1: begin
                if (rx_byte != sum_a_reg) begin
                    ev      = EV_CKA_BAD;
                    restart = 1'b1;
                end else begin
                    state_next = ST_CK2;
                end
            end
            ST_CK2: begin
                ev      = (rx_byte == sum_b_reg) ? EV_GOOD : EV_CKB_BAD;
                restart = 1'b1;
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // frame length is reported before the restart clears it
        result.event_res    = ev;
        result.payload_byte = pbyte;
        result.byte_index   = pidx;
        result.msg_class    = class_next;
        result.msg_id       = id_next;
        result.frame_length = length_next;

        if (restart) begin
            state_next  = ST_SYNC1;
            sum_a_next  = 8'd0;
            sum_b_next  = 8'd0;
            length_next = 16'd0;
            pos_next    = 16'd0;
            ff_next     = 8'd0;
        end

        result.idle_count   = ff_next;
        result.idle_timeout = (ff_next >= cfg.idle_limit);
    end

    assign status.hunting = (state_reg == ST_SYNC1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SYNC1;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            length_reg <= 16'd0;
            pos_reg    <= 16'd0;
            class_reg  <= 8'd0;
            id_reg     <= 8'd0;
            ff_reg     <= 8'd0;
        end else if (step) begin
            state_reg  <= state_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            ff_reg     <= ff_next;
        end
    end

endmodule

// ===== hw/rtl/gnss_binary_frame_receiver.sv =====
// Binary GNSS frame receiver with a Fletcher-8 checksum.
// Input channel (s_valid/s_ready, s_rx_byte) takes one received byte per beat.
// Result channel (m_valid/m_ready, m_*) gives exactly one result beat per input
// beat: an event code (none, payload byte, frame good, ck_a bad, ck_b bad,
// overflow) with the payload byte and its index, the class, id and declared
// length of the current frame, and the idle 0xFF count with its timeout flag.
// The result of a byte sits in the output register in the cycle after the byte
// is accepted. Throughput is one byte per cycle while the receiver keeps taking
// results; the parser state update and the two checksum adds are combinational.
// If the receiver stalls, the output register holds its beat and s_ready
// stays high only as long as the register frees up in the same cycle, so the
// input is held off one-for-one with the stall.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must write
// only while the block is idle (not enforced); indexes: max_payload, idle_limit, sync_first, sync_second.
// Synchronous active-low reset puts the parser hunting the first sync byte,
// clears checksums, counters, class and id, empties the output register and
// loads the default configuration (1024, 50, 0xB5, 0x62).
module gnss_binary_frame_receiver (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [gbfr_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [gbfr_pkg::CfgDataWidth-1:0]     cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_rx_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_event_res,
    output logic [7:0]                            m_payload_byte,
    output logic [15:0]                           m_byte_index,
    output logic [7:0]                            m_msg_class,
    output logic [7:0]                            m_msg_id,
    output logic [15:0]                           m_frame_length,
    output logic [7:0]                            m_idle_count,
    output logic                                  m_idle_timeout
);
    import gbfr_pkg::*;

    cfg_t         cfg_reg;
    result_t      core_result;
    core_status_t core_status;
    result_t      out_reg;
    logic         m_valid_reg;
    logic         accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload <= MaxPayloadReset;
            cfg_reg.idle_limit  <= IdleLimitReset;
            cfg_reg.sync_first  <= SyncFirstReset;
            cfg_reg.sync_second <= SyncSecondReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wdata;
                REG_IDLE_LIMIT:  cfg_reg.idle_limit  <= cfg_wdata[7:0];
                REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_wdata[7:0];
                REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    gbfr_parser_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .rx_byte (s_rx_byte),
        .cfg     (cfg_reg),
        .result  (core_result),
        .status  (core_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= core_result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = out_reg.event_res;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_byte_index   = out_reg.byte_index;
    assign m_msg_class    = out_reg.msg_class;
    assign m_msg_id       = out_reg.msg_id;
    assign m_frame_length = out_reg.frame_length;
    assign m_idle_count   = out_reg.idle_count;
    assign m_idle_timeout = out_reg.idle_timeout;

`ifndef NO_ASSERTIONS
    a_accept_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted byte produced no result beat");

    a_non_payload_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_PAYLOAD)
        |-> (m_payload_byte == 8'd0 && m_byte_index == 16'd0))
        else $error("payload fields set on a non-payload event");

    a_frame_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (core_result.event_res == EV_GOOD || core_result.event_res == EV_CKA_BAD ||
                    core_result.event_res == EV_CKB_BAD || core_result.event_res == EV_OVERFLOW))
        |=> core_status.hunting)
        else $error("parser not hunting after frame end");

    a_end_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_NONE) |-> (m_idle_count == 8'd0))
        else $error("idle count nonzero during a frame");
`endif

endmodule
